FILE: rtl/gsr_pkg.sv
// gsr_pkg: shared types and constants of the generational slot registry
// depends on nothing; used by the registry top level, its property checker and the testbench

package gsr_pkg;

    // table size default and field widths
    localparam int SLOTS_DEFAULT = 64;
    localparam int KEY_W         = 64;
    localparam int GEN_W         = 16;
    localparam int STATUS_W      = 3;

    // generation values
    localparam logic [GEN_W-1:0] GEN_RESET   = 16'd1;
    localparam logic [GEN_W-1:0] GEN_INVALID = 16'd0;
    localparam logic [GEN_W-1:0] GEN_LIMIT   = 16'hFFFF;

    // request kinds
    localparam logic REQ_REGISTER   = 1'b0;
    localparam logic REQ_UNREGISTER = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_DUPLICATE     = 3'd1,
        ST_NOT_FOUND     = 3'd2,
        ST_FULL          = 3'd3,
        ST_GEN_EXHAUSTED = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_POP,
        S_GEN_RD,
        S_UPDATE,
        S_RESP
    } state_t;

endpackage

FILE: rtl/gsr_ram.sv
// gsr_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module gsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/generational_slot_registry.sv
// generational_slot_registry: keyed slot table with generation-stamped handles
// depends on gsr_pkg and gsr_ram (key store, generation store, free stack)
//
//  channel | signals                               | direction | word
//  --------+---------------------------------------+-----------+---------------------------
//  req     | req_valid, req_ready                  | in        | req_type, key_x/y/z
//  rsp     | rsp_valid, rsp_ready                  | out       | status, slot_index, gen
//
//  one request at a time; req_ready is low from accept until the result is loaded
//  the key scan reads one stored key per cycle from the key ram and stops at the
//  first hit or after the last slot; bookkeeping (decide, and as needed free stack
//  pop, generation read and table update) and result load follow, and the
//  sequencer passes through idle before the next accept
//  a result waits in the output register while the next request is accepted; a
//  stalled rsp side holds the sequencer only when a second result is ready
//  reset clears use marks, generation valid bits and counters at once; no clearing pass

module generational_slot_registry #(
    parameter int SLOTS = gsr_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_type,
    input  logic [gsr_pkg::KEY_W-1:0]       key_x,
    input  logic [gsr_pkg::KEY_W-1:0]       key_y,
    input  logic [gsr_pkg::KEY_W-1:0]       key_z,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [gsr_pkg::STATUS_W-1:0]    status,
    output logic [$clog2(SLOTS)-1:0]        slot_index,
    output logic [gsr_pkg::GEN_W-1:0]       slot_generation
);

    import gsr_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEYS_W = 3 * KEY_W;

    localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);

    // sequencer and request state
    state_t              state_reg, state_next;
    logic                req_reg, req_next;
    logic [KEYS_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;

    // table bookkeeping
    logic [SLOTS-1:0]    in_use_reg, in_use_next;
    logic [SLOTS-1:0]    gen_ok_reg, gen_ok_next;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    ever_used_reg, ever_used_next;

    // output register
    logic                rsp_valid_reg, rsp_valid_next;
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic [GEN_W-1:0]    res_gen_reg, res_gen_next;
    status_t             out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_slot_reg, out_slot_next;
    logic [GEN_W-1:0]    out_gen_reg, out_gen_next;

    // ram ports
    logic                key_we;
    logic [IDX_W-1:0]    key_raddr;
    logic [KEYS_W-1:0]   key_rdata;
    logic                gen_we;
    logic [GEN_W-1:0]    gen_wdata;
    logic [GEN_W-1:0]    gen_rdata;
    logic                fs_we;
    logic [IDX_W-1:0]    fs_waddr;
    logic [IDX_W-1:0]    fs_raddr;
    logic [IDX_W-1:0]    fs_rdata;

    logic                key_match;
    logic [GEN_W-1:0]    gen_cur;
    logic [CNT_W-1:0]    free_top;

    // stored keys, one row per slot
    gsr_ram #(.WIDTH(KEYS_W), .DEPTH(SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // generation per slot; an unwritten entry reads as the reset generation
    gsr_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (slot_reg),
        .wdata (gen_wdata),
        .raddr (slot_reg),
        .rdata (gen_rdata)
    );

    // lifo of freed slots
    gsr_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (slot_reg),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    // compare of the key read in the previous cycle
    assign key_match = cmp_valid_reg && in_use_reg[cmp_idx_reg] && (key_rdata == key_reg);
    assign gen_cur   = gen_ok_reg[slot_reg] ? gen_rdata : GEN_RESET;
    assign free_top  = free_count_reg - CNT_W'(1);
    assign gen_wdata = gen_cur + GEN_W'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        scan_addr_next  = scan_addr_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        in_use_next     = in_use_reg;
        gen_ok_next     = gen_ok_reg;
        free_count_next = free_count_reg;
        ever_used_next  = ever_used_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_gen_next    = res_gen_reg;
        rsp_valid_next  = rsp_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_gen_next    = out_gen_reg;
        key_we          = 1'b0;
        key_raddr       = scan_addr_reg[IDX_W-1:0];
        gen_we          = 1'b0;
        fs_we           = 1'b0;
        fs_waddr        = free_count_reg[IDX_W-1:0];
        fs_raddr        = free_top[IDX_W-1:0];
        req_ready       = (state_reg == S_IDLE);

        // result word leaves the output register
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req_type;
                    key_next       = {key_x, key_y, key_z};
                    scan_addr_next = '0;
                    state_next     = S_SCAN;
                end
            end

            // one stored key read and one compare per cycle
            S_SCAN:
            begin
                if (scan_addr_reg < CNT_SLOTS)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                if (key_match)
                begin
                    hit_next   = 1'b1;
                    slot_next  = cmp_idx_reg;
                    state_next = S_DECIDE;
                end
                else if (cmp_valid_reg && (cmp_idx_reg == IDX_LAST))
                begin
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            // choose a slot or fail
            S_DECIDE:
            begin
                res_slot_next = '0;
                res_gen_next  = GEN_INVALID;
                if (req_reg == REQ_REGISTER)
                begin
                    priority if (hit_reg)
                    begin
                        res_status_next = ST_DUPLICATE;
                        state_next      = S_RESP;
                    end
                    else if (free_count_reg != '0)
                    begin
                        free_count_next = free_top;
                        state_next      = S_POP;
                    end
                    else if (ever_used_reg < CNT_SLOTS)
                    begin
                        slot_next      = ever_used_reg[IDX_W-1:0];
                        ever_used_next = ever_used_reg + CNT_W'(1);
                        state_next     = S_GEN_RD;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESP;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        state_next = S_GEN_RD;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_RESP;
                    end
                end
            end

            // free stack read data is back
            S_POP:
            begin
                slot_next  = fs_rdata;
                state_next = S_GEN_RD;
            end

            // generation read of the chosen slot is in flight
            S_GEN_RD:
            begin
                state_next = S_UPDATE;
            end

            // table update and result
            S_UPDATE:
            begin
                state_next = S_RESP;
                if (req_reg == REQ_REGISTER)
                begin
                    key_we                = 1'b1;
                    in_use_next[slot_reg] = 1'b1;
                    res_status_next       = ST_OK;
                    res_slot_next         = slot_reg;
                    res_gen_next          = gen_cur;
                end
                else
                begin
                    in_use_next[slot_reg] = 1'b0;
                    if (gen_cur >= (GEN_LIMIT - GEN_W'(1)))
                    begin
                        // slot retired: generation kept, not pushed
                        res_status_next = ST_GEN_EXHAUSTED;
                        res_slot_next   = '0;
                        res_gen_next    = GEN_INVALID;
                    end
                    else
                    begin
                        gen_we                = 1'b1;
                        gen_ok_next[slot_reg] = 1'b1;
                        if (free_count_reg < CNT_SLOTS)
                        begin
                            fs_we           = 1'b1;
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                        res_status_next = ST_OK;
                        res_slot_next   = slot_reg;
                        res_gen_next    = gen_cur;
                    end
                end
            end

            // hand the result word to the output register once it is free
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_gen_next    = res_gen_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmp_valid_reg  <= 1'b0;
            in_use_reg     <= '0;
            gen_ok_reg     <= '0;
            free_count_reg <= '0;
            ever_used_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_valid_reg  <= cmp_valid_next;
            in_use_reg     <= in_use_next;
            gen_ok_reg     <= gen_ok_next;
            free_count_reg <= free_count_next;
            ever_used_reg  <= ever_used_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        scan_addr_reg  <= scan_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_gen_reg    <= res_gen_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_gen_reg    <= out_gen_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = out_status_reg;
    assign slot_index      = out_slot_reg;
    assign slot_generation = out_gen_reg;

endmodule

FILE: rtl/gsr_checker.sv
// gsr_props: port-level checks of the generational slot registry
// depends on gsr_pkg; bound to generational_slot_registry below

module gsr_props #(
    parameter int SLOTS = gsr_pkg::SLOTS_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [gsr_pkg::STATUS_W-1:0] status,
    input logic [$clog2(SLOTS)-1:0]     slot_index,
    input logic [gsr_pkg::GEN_W-1:0]    slot_generation
);

    import gsr_pkg::*;

    // stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(slot_index) && $stable(slot_generation))
        else $error("result word changed while stalled");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is still running");

    // failed requests carry an empty handle
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (slot_index == '0) && (slot_generation == GEN_INVALID))
        else $error("failed request returned a handle");

    // a good handle never has the invalid generation
    a_ok_gen: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_OK) |-> (slot_generation != GEN_INVALID))
        else $error("good handle with invalid generation");

    // only defined result codes
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ST_OK) || (status == ST_DUPLICATE)
            || (status == ST_NOT_FOUND) || (status == ST_FULL)
            || (status == ST_GEN_EXHAUSTED))
        else $error("undefined result code");

endmodule

bind generational_slot_registry gsr_props #(.SLOTS(SLOTS)) u_gsr_props (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .status          (status),
    .slot_index      (slot_index),
    .slot_generation (slot_generation)
);

FILE: tb/sv/gsr_checker.sv
`timescale 1ns / 100ps
// gsr_checker: watches both channels of the slot registry, predicts each handle and compares
// depends on gsr_pkg; instantiated beside the registry by tb

module gsr_checker #(
    parameter int SLOTS = gsr_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  logic                            req_type,
    input  logic [gsr_pkg::KEY_W-1:0]       key_x,
    input  logic [gsr_pkg::KEY_W-1:0]       key_y,
    input  logic [gsr_pkg::KEY_W-1:0]       key_z,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic [gsr_pkg::STATUS_W-1:0]    status,
    input  logic [$clog2(SLOTS)-1:0]        slot_index,
    input  logic [gsr_pkg::GEN_W-1:0]       slot_generation,
    output int                              mismatches,
    output int                              outstanding
);

    import gsr_pkg::*;

    localparam int IDX_W      = $clog2(SLOTS);
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        status_t            code;
        logic [IDX_W-1:0]   index;
        logic [GEN_W-1:0]   gen;
    } handle_t;

    // mirror of the registry
    logic               slot_busy [SLOTS];
    logic [GEN_W-1:0]   slot_gen  [SLOTS];
    logic [KEY_W-1:0]   held_x    [SLOTS];
    logic [KEY_W-1:0]   held_y    [SLOTS];
    logic [KEY_W-1:0]   held_z    [SLOTS];
    logic [IDX_W-1:0]   free_slots[SLOTS];
    int                 free_depth;
    int                 fresh_next;
    int                 fail_count;

    handle_t            expected_handles[$];
    handle_t            want;

    // in-use slot holding the location, SLOTS when there is none
    function automatic int find_slot(input logic [KEY_W-1:0] x, y, z);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_busy[i] && held_x[i] == x && held_y[i] == y && held_z[i] == z)
                return i;
        end
        return SLOTS;
    endfunction

    // applies one request to the mirror and yields the handle it returns
    task automatic predict_handle(input logic kind, input logic [KEY_W-1:0] x, y, z,
                                  output handle_t h);
        int hit;
        int idx;
        hit     = find_slot(x, y, z);
        h.code  = ST_OK;
        h.index = '0;
        h.gen   = GEN_INVALID;
        if (kind == REQ_REGISTER)
        begin
            if (hit < SLOTS)
                h.code = ST_DUPLICATE;
            else
            begin
                // free stack first, then a slot never handed out
                idx = -1;
                if (free_depth > 0)
                begin
                    free_depth--;
                    idx = int'(free_slots[free_depth]);
                end
                else if (fresh_next < SLOTS)
                begin
                    idx = fresh_next;
                    fresh_next++;
                end
                if (idx < 0)
                    h.code = ST_FULL;
                else
                begin
                    held_x[idx]    = x;
                    held_y[idx]    = y;
                    held_z[idx]    = z;
                    slot_busy[idx] = 1'b1;
                    h.index        = idx[IDX_W-1:0];
                    h.gen          = slot_gen[idx];
                end
            end
        end
        else if (hit >= SLOTS)
            h.code = ST_NOT_FOUND;
        else
        begin
            slot_busy[hit] = 1'b0;
            // a slot whose next generation would hit the limit is retired
            if ({1'b0, slot_gen[hit]} + 17'd1 >= {1'b0, GEN_LIMIT})
                h.code = ST_GEN_EXHAUSTED;
            else
            begin
                h.index       = hit[IDX_W-1:0];
                h.gen         = slot_gen[hit];
                slot_gen[hit] = slot_gen[hit] + GEN_W'(1);
                if (free_depth < SLOTS)
                begin
                    free_slots[free_depth] = hit[IDX_W-1:0];
                    free_depth++;
                end
            end
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    // compare the accepted result word, then predict the accepted request word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_busy[i]  = 1'b0;
                slot_gen[i]   = GEN_RESET;
                held_x[i]     = '0;
                held_y[i]     = '0;
                held_z[i]     = '0;
                free_slots[i] = '0;
            end
            free_depth = 0;
            fresh_next = 0;
            fail_count = 0;
            expected_handles.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_handles.size() == 0)
                    note_failure($sformatf("result word with none expected: status %0d index %0d gen %0d",
                                           status, slot_index, slot_generation));
                else
                begin
                    want = expected_handles.pop_front();
                    if (status !== want.code || slot_index !== want.index ||
                        slot_generation !== want.gen)
                        note_failure($sformatf(
                            "handle mismatch: expected status %0d index %0d gen %0d, got %0d %0d %0d",
                            want.code, want.index, want.gen, status, slot_index, slot_generation));
                end
            end
            if (req_valid && req_ready)
            begin
                predict_handle(req_type, key_x, key_y, key_z, want);
                expected_handles.push_back(want);
            end
            mismatches  <= fail_count;
            outstanding <= expected_handles.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for the generational slot registry
// depends on gsr_pkg, generational_slot_registry and gsr_checker

module tb;

    import gsr_pkg::*;

    localparam int SLOTS           = SLOTS_DEFAULT;
    localparam int IDX_W           = $clog2(SLOTS);
    localparam int IDLE_LIMIT      = 4000;
    localparam int ITEMS_PER_PHASE = 626;

    localparam logic [KEY_W-1:0] ALL_ZERO = '0;
    localparam logic [KEY_W-1:0] ALL_ONE  = '1;
    localparam logic [KEY_W-1:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [KEY_W-1:0] ALT_5    = 64'h5555_5555_5555_5555;
    localparam logic [KEY_W-1:0] LOW_BIT  = 64'h0000_0000_0000_0001;
    localparam logic [KEY_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [KEY_W-1:0] x;
        logic [KEY_W-1:0] y;
        logic [KEY_W-1:0] z;
    } location_t;

    typedef enum {ADD_FRESH, ADD_AGAIN, DROP_LIVE, DROP_ABSENT} pick_t;

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;
    logic                   req_valid       = 1'b0;
    logic                   req_ready;
    logic                   req_type        = REQ_REGISTER;
    logic [KEY_W-1:0]       key_x           = '0;
    logic [KEY_W-1:0]       key_y           = '0;
    logic [KEY_W-1:0]       key_z           = '0;
    logic                   rsp_valid;
    logic                   rsp_ready       = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [IDX_W-1:0]       slot_index;
    logic [GEN_W-1:0]       slot_generation;

    int                     tx_idle_pct     = 6;
    int                     rx_idle_pct     = 50;
    int                     idle_cycles     = 0;
    int                     mismatches;
    int                     outstanding;
    bit                     filling         = 1'b1;
    location_t              live_keys[$];

    generational_slot_registry #(
        .SLOTS(SLOTS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .key_x          (key_x),
        .key_y          (key_y),
        .key_z          (key_z),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .slot_index     (slot_index),
        .slot_generation(slot_generation)
    );

    gsr_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_type       (req_type),
        .key_x          (key_x),
        .key_y          (key_y),
        .key_z          (key_z),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .slot_index     (slot_index),
        .slot_generation(slot_generation),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side stalls at random
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog on cycles where no word moves on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // one request word: random gap, then hold until accepted; returns at a falling edge
    task automatic send_word(input logic kind, input location_t loc);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= kind;
        key_x     <= loc.x;
        key_y     <= loc.y;
        key_z     <= loc.z;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        req_valid <= 1'b0;
        @(posedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(negedge clk);
    endtask

    // coordinate with a bias toward the all-zero and all-one patterns
    function automatic logic [KEY_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return ALL_ZERO;
            1:       return ALL_ONE;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic location_t fresh_location();
        location_t loc;
        int        flip;
        loc = {random_coord(), random_coord(), random_coord()};
        // near miss: a live location with one bit flipped
        if (live_keys.size() > 0 && $urandom_range(0, 4) == 0)
        begin
            loc       = live_keys[$urandom_range(0, live_keys.size() - 1)];
            flip      = $urandom_range(0, 3 * KEY_W - 1);
            loc[flip] = ~loc[flip];
        end
        return loc;
    endfunction

    // fill the table past full, then drain it, over and over
    task automatic run_phase(input int count);
        location_t loc;
        pick_t     pick;
        int        r;
        int        k;
        for (int n = 0; n < count; n++)
        begin
            if (live_keys.size() >= SLOTS + 4)
                filling = 1'b0;
            else if (live_keys.size() <= 2)
                filling = 1'b1;
            r = $urandom_range(0, 99);
            if (filling)
                pick = (r < 70) ? ADD_FRESH : (r < 80) ? ADD_AGAIN : (r < 90) ? DROP_LIVE : DROP_ABSENT;
            else
                pick = (r < 70) ? DROP_LIVE : (r < 80) ? ADD_FRESH : (r < 90) ? ADD_AGAIN : DROP_ABSENT;
            if (live_keys.size() == 0 && (pick == ADD_AGAIN || pick == DROP_LIVE))
                pick = ADD_FRESH;
            case (pick)
                ADD_FRESH:
                begin
                    loc = fresh_location();
                    live_keys.push_back(loc);
                    send_word(REQ_REGISTER, loc);
                end
                ADD_AGAIN:
                begin
                    loc = live_keys[$urandom_range(0, live_keys.size() - 1)];
                    send_word(REQ_REGISTER, loc);
                end
                DROP_LIVE:
                begin
                    k   = $urandom_range(0, live_keys.size() - 1);
                    loc = live_keys[k];
                    live_keys.delete(k);
                    send_word(REQ_UNREGISTER, loc);
                end
                default:
                begin
                    loc = fresh_location();
                    send_word(REQ_UNREGISTER, loc);
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extreme patterns, duplicates, misses, reuse in stack order
        send_word(REQ_REGISTER,   {ALL_ZERO, ALL_ZERO, ALL_ZERO});
        send_word(REQ_REGISTER,   {ALL_ONE,  ALL_ONE,  ALL_ONE});
        send_word(REQ_REGISTER,   {ALL_ZERO, ALL_ZERO, ALL_ZERO});
        send_word(REQ_REGISTER,   {ALL_ZERO, ALL_ZERO, ALL_ONE});
        send_word(REQ_REGISTER,   {ALL_ONE,  ALL_ZERO, ALL_ZERO});
        send_word(REQ_REGISTER,   {ALL_ZERO, ALL_ONE,  ALL_ZERO});
        send_word(REQ_UNREGISTER, {ALT_A,    ALT_5,    ALT_A});
        send_word(REQ_UNREGISTER, {ALL_ONE,  ALL_ONE,  ALL_ONE});
        send_word(REQ_UNREGISTER, {ALL_ONE,  ALL_ONE,  ALL_ONE});
        send_word(REQ_REGISTER,   {ALT_A,    ALT_5,    ALT_A});
        send_word(REQ_UNREGISTER, {ALL_ZERO, ALL_ZERO, ALL_ZERO});
        send_word(REQ_UNREGISTER, {ALL_ZERO, ALL_ZERO, ALL_ONE});
        send_word(REQ_REGISTER,   {ALT_5,    ALT_A,    ALT_5});
        send_word(REQ_REGISTER,   {ALL_ZERO, ALL_ZERO, ALL_ZERO});
        send_word(REQ_REGISTER,   {ALL_ZERO, ALL_ZERO, LOW_BIT});
        send_word(REQ_REGISTER,   {TOP_BIT,  ALL_ZERO, ALL_ZERO});
        send_word(REQ_UNREGISTER, {ALT_A,    ALT_5,    ALT_A});
        send_word(REQ_UNREGISTER, {ALT_5,    ALT_A,    ALT_5});
        send_word(REQ_UNREGISTER, {ALL_ZERO, ALL_ZERO, ALL_ZERO});
        send_word(REQ_UNREGISTER, {ALL_ZERO, ALL_ZERO, LOW_BIT});
        send_word(REQ_UNREGISTER, {TOP_BIT,  ALL_ZERO, ALL_ZERO});
        send_word(REQ_UNREGISTER, {ALL_ONE,  ALL_ZERO, ALL_ZERO});
        send_word(REQ_UNREGISTER, {ALL_ZERO, ALL_ONE,  ALL_ZERO});
        send_word(REQ_UNREGISTER, {ALL_ZERO, ALL_ZERO, ALL_ONE});

        // random: slow result side, then slow request side, then full speed
        run_phase(ITEMS_PER_PHASE);
        set_idling(50, 6);
        run_phase(ITEMS_PER_PHASE);
        set_idling(0, 0);
        run_phase(ITEMS_PER_PHASE);
        req_valid <= 1'b0;

        // drain, then let a late stray word show up
        while (outstanding != 0)
            @(negedge clk);
        repeat (SLOTS + 16) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: generational_slot_registry.f
rtl/gsr_pkg.sv
rtl/gsr_ram.sv
rtl/generational_slot_registry.sv
rtl/gsr_checker.sv
tb/sv/gsr_checker.sv
tb/sv/tb.sv
